[rtl/pce_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PSG command encoder.
// Used by every module under rtl/; depends on nothing.
package pce_pkg;

   localparam int TONE_CLOCK_W = 17;
   localparam logic [TONE_CLOCK_W-1:0] TONE_CLOCK_RESET = 17'd111860;

   localparam int FREQ_W = 16;
   localparam int DIV_W  = 10;
   localparam logic [DIV_W-1:0] DIV_MAX = 10'h3FF;

   localparam int CMD_DEPTH_DEF = 2;
   localparam int OUT_DEPTH_DEF = 2;

   localparam logic [1:0] KIND_TONE    = 2'd0;
   localparam logic [1:0] KIND_NOISE   = 2'd1;
   localparam logic [1:0] KIND_SILENCE = 2'd2;

   localparam logic [1:0] OP_TONE    = 2'd0;
   localparam logic [1:0] OP_MUTE    = 2'd1;
   localparam logic [1:0] OP_NOISE   = 2'd2;
   localparam logic [1:0] OP_SILENCE = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        channel;
      logic [3:0]        volume;
      logic [2:0]        noise_type;
      logic [FREQ_W-2:0] freq;
      logic              sat;
   } cmd_entry_type;

endpackage

[rtl/pce_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues commands.
// Depends on pce_pkg.
module pce_front #(
   parameter int CMD_DEPTH = pce_pkg::CMD_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [2:0]                        req_channel,
   input  logic signed [pce_pkg::FREQ_W-1:0] req_frequency,
   input  logic [3:0]                        req_volume,
   input  logic [2:0]                        req_noise_type,
   input  logic [pce_pkg::TONE_CLOCK_W-1:0]  tone_clock,
   output logic                              cmd_valid,
   output pce_pkg::cmd_entry_type            cmd_entry,
   input  logic                              cmd_pop
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int SH_W  = pce_pkg::FREQ_W - 1 + pce_pkg::DIV_W;

   pce_pkg::cmd_entry_type mem [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   pce_pkg::cmd_entry_type entry;
   logic keep;
   logic push;
   logic pop;
   logic nonpos;

   always_comb begin
      nonpos           = req_frequency[pce_pkg::FREQ_W-1] || (req_frequency == '0);
      entry.channel    = req_channel[1:0];
      entry.volume     = req_volume;
      entry.noise_type = req_noise_type;
      entry.freq       = req_frequency[pce_pkg::FREQ_W-2:0];
      entry.sat        = {{(SH_W-pce_pkg::TONE_CLOCK_W){1'b0}}, tone_clock} >=
                         {req_frequency[pce_pkg::FREQ_W-2:0], {pce_pkg::DIV_W{1'b0}}};
      entry.op         = pce_pkg::OP_TONE;
      keep             = 1'b0;
      unique case (req_kind)
         pce_pkg::KIND_TONE: begin
            keep     = (req_channel <= 3'd2);
            entry.op = nonpos ? pce_pkg::OP_MUTE : pce_pkg::OP_TONE;
         end
         pce_pkg::KIND_NOISE: begin
            keep     = 1'b1;
            entry.op = pce_pkg::OP_NOISE;
         end
         pce_pkg::KIND_SILENCE: begin
            keep     = 1'b1;
            entry.op = pce_pkg::OP_SILENCE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_full  = (cnt_ff == CNT_W'(CMD_DEPTH));
   assign push      = req_push && !req_full && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= entry;
      end
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CMD_DEPTH))
      else $error("command queue count out of range");
   a_no_phantom_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |=> (cnt_ff <= CNT_W'(1)))
      else $error("command queue grew by more than one word");
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1))
      else $error("command queue pop lost");
`endif

endmodule

[rtl/pce_divider.sv]
`timescale 1ns / 1ps
// Iterative tone divider: two quotient bits per cycle, ten bits in total.
// Depends on pce_pkg.
module pce_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pce_pkg::TONE_CLOCK_W-1:0] dividend,
   input  logic [pce_pkg::FREQ_W-2:0]       divisor,
   output logic                             busy,
   output logic                             done,
   output logic [pce_pkg::DIV_W-1:0]        quotient
);

   localparam int STEPS = pce_pkg::DIV_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int D_W   = pce_pkg::FREQ_W - 1 + pce_pkg::DIV_W - 1;
   localparam int R_W   = pce_pkg::TONE_CLOCK_W;

   logic [R_W-1:0]               rem_ff, rem_in;
   logic [D_W-1:0]               dsh_ff, dsh_in;
   logic [pce_pkg::DIV_W-1:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [D_W-1:0]               d_lo;
   logic                         ge1, ge2;
   logic [R_W-1:0]               r1, r2;

   always_comb begin
      d_lo    = dsh_ff >> 1;
      ge1     = {{(D_W-R_W){1'b0}}, rem_ff} >= dsh_ff;
      r1      = ge1 ? rem_ff - dsh_ff[R_W-1:0] : rem_ff;
      ge2     = {{(D_W-R_W){1'b0}}, r1} >= d_lo;
      r2      = ge2 ? r1 - d_lo[R_W-1:0] : r1;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = {divisor, {(pce_pkg::DIV_W-1){1'b0}}};
         quot_in = '0;
         cnt_in  = CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = r2;
         dsh_in  = dsh_ff >> 2;
         quot_in = {quot_ff[pce_pkg::DIV_W-3:0], ge1, ge2};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quot_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("divider restarted while busy");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(cnt_ff) == CNT_W'(1))
      else $error("divider done without a final step");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy && cnt_ff == CNT_W'(STEPS)) |-> $past(start))
      else $error("divider run did not begin with start");
`endif

endmodule

[rtl/pce_back.sv]
`timescale 1ns / 1ps
// Back end: runs queued commands, builds command bytes and buffers them.
// Depends on pce_pkg and pce_divider.
module pce_back #(
   parameter int OUT_DEPTH = pce_pkg::OUT_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pce_pkg::TONE_CLOCK_W-1:0] tone_clock,
   input  logic                             cmd_valid,
   input  pce_pkg::cmd_entry_type           cmd_entry,
   output logic                             cmd_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_byte_res,
   output logic                             rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   function automatic logic [8:0] make_word(pce_pkg::cmd_entry_type e, logic [1:0] idx,
                                            logic [pce_pkg::DIV_W-1:0] q);
      logic [8:0] w;
      w = '0;
      unique case (e.op)
         pce_pkg::OP_TONE: begin
            unique case (idx)
               2'd0:    w = {1'b0, 1'b1, e.channel, 1'b0, q[3:0]};
               2'd1:    w = {1'b0, 2'b00, q[pce_pkg::DIV_W-1:4]};
               default: w = {1'b1, 1'b1, e.channel, 1'b1, e.volume};
            endcase
         end
         pce_pkg::OP_MUTE: begin
            w = {1'b1, 1'b1, e.channel, 1'b1, 4'hF};
         end
         pce_pkg::OP_NOISE: begin
            w = (idx == 2'd0) ? {1'b0, 5'b11100, e.noise_type}
                              : {1'b1, 4'hF, e.volume};
         end
         default: begin
            w = {(idx == 2'd3), 1'b1, idx, 1'b1, 4'hF};
         end
      endcase
      return w;
   endfunction

   logic [1:0]                state_ff, state_in;
   pce_pkg::cmd_entry_type    entry_ff, entry_in;
   logic [1:0]                idx_ff, idx_in;
   logic [pce_pkg::DIV_W-1:0] quot_ff, quot_in;
   logic                      div_start, div_busy, div_done;
   logic [pce_pkg::DIV_W-1:0] div_quot;
   logic [8:0]                word;
   logic                      emit;
   logic                      load;

   logic [8:0]       oq_mem [OUT_DEPTH];
   logic [PTR_W-1:0] owr_ff, owr_in, ord_ff, ord_in;
   logic [CNT_W-1:0] ocnt_ff, ocnt_in;
   logic             oq_full;
   logic             opop;

   pce_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tone_clock),
      .divisor  (cmd_entry.freq),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign oq_full   = (ocnt_ff == CNT_W'(OUT_DEPTH));
   assign word      = make_word(entry_ff, idx_ff, quot_ff);
   assign emit      = (state_ff == ST_EMIT) && !oq_full;
   assign load      = cmd_valid && ((state_ff == ST_IDLE) || (emit && word[8]));
   assign cmd_pop   = load;
   assign div_start = load && (cmd_entry.op == pce_pkg::OP_TONE) && !cmd_entry.sat;

   always_comb begin
      state_in = state_ff;
      entry_in = entry_ff;
      idx_in   = idx_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_DIV: begin
            if (div_done) begin
               quot_in  = div_quot;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               idx_in = idx_ff + 1'b1;
               if (word[8]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         entry_in = cmd_entry;
         idx_in   = '0;
         quot_in  = pce_pkg::DIV_MAX;
         state_in = div_start ? ST_DIV : ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      idx_ff   <= idx_in;
      quot_ff  <= quot_in;
   end

   assign rsp_empty    = (ocnt_ff == '0);
   assign opop         = rsp_pop && !rsp_empty;
   assign rsp_byte_res = oq_mem[ord_ff][7:0];
   assign rsp_last     = oq_mem[ord_ff][8];

   always_comb begin
      owr_in  = owr_ff;
      ord_in  = ord_ff;
      ocnt_in = ocnt_ff;
      if (emit) begin
         owr_in = (owr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : owr_ff + 1'b1;
      end
      if (opop) begin
         ord_in = (ord_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : ord_ff + 1'b1;
      end
      if (emit && !opop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (opop && !emit) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         oq_mem[owr_ff] <= word;
      end
   end

`ifndef SYNTHESIS
   a_sat_quot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && entry_ff.op == pce_pkg::OP_TONE && entry_ff.sat)
         |-> (quot_ff == pce_pkg::DIV_MAX))
      else $error("saturated tone lost its clamped divider");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= CNT_W'(OUT_DEPTH))
      else $error("output queue count out of range");
   a_emit_idx: assert property (@(posedge clock) disable iff (reset)
      (emit && !word[8]) |=> (idx_ff == $past(idx_ff) + 1'b1))
      else $error("byte index did not advance");
`endif

endmodule

[rtl/psg_command_encoder.sv]
`timescale 1ns / 1ps
// PSG command encoder top: tone clock register, front end and back end.
// Depends on pce_pkg, pce_front and pce_back.
// Throughput: one word per cycle while the output queue has room and no division runs;
//   per request mute 1, noise 2, tone 3 and silence 4 words. A tone that is not clamped
//   first runs the 5-step divider (2 quotient bits per divider step).
// Reset: synchronous, clears both queues and the sequencer; tone clock goes to 111860.
module psg_command_encoder #(
   parameter int CMD_DEPTH = pce_pkg::CMD_DEPTH_DEF,
   parameter int OUT_DEPTH = pce_pkg::OUT_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [1:0]                        req_kind,
   input  logic [2:0]                        req_channel,
   input  logic signed [pce_pkg::FREQ_W-1:0] req_frequency,
   input  logic [3:0]                        req_volume,
   input  logic [2:0]                        req_noise_type,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [7:0]                        rsp_byte_res,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [pce_pkg::TONE_CLOCK_W-1:0]  csr_wdata
);

   logic [pce_pkg::TONE_CLOCK_W-1:0] tone_clock_ff;
   logic                             cmd_valid;
   logic                             cmd_pop;
   pce_pkg::cmd_entry_type           cmd_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_clock_ff <= pce_pkg::TONE_CLOCK_RESET;
      end else if (csr_we) begin
         tone_clock_ff <= csr_wdata;
      end
   end

   pce_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_frequency  (req_frequency),
      .req_volume     (req_volume),
      .req_noise_type (req_noise_type),
      .tone_clock     (tone_clock_ff),
      .cmd_valid      (cmd_valid),
      .cmd_entry      (cmd_entry),
      .cmd_pop        (cmd_pop)
   );

   pce_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .tone_clock   (tone_clock_ff),
      .cmd_valid    (cmd_valid),
      .cmd_entry    (cmd_entry),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_byte_res (rsp_byte_res),
      .rsp_last     (rsp_last)
   );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for psg_command_encoder: random and directed sound requests and tone clock writes.
// Every command word is predicted and checked in order. Depends on pce_pkg and the RTL.

typedef struct packed {
   logic [7:0] code;
   logic       last;
} cmd_word_type;

class cmd_byte_ledger;
   localparam logic [7:0] TONE_LATCH_CMD  = 8'h80;
   localparam logic [7:0] TONE_ATTEN_CMD  = 8'h90;
   localparam logic [7:0] NOISE_CTRL_CMD  = 8'hE0;
   localparam logic [7:0] NOISE_ATTEN_CMD = 8'hF0;
   localparam logic [3:0] ATTEN_OFF       = 4'hF;

   logic [16:0]  tone_clock;
   cmd_word_type pending_bytes[$];
   int           fails;

   function new();
      tone_clock = pce_pkg::TONE_CLOCK_RESET;
      fails = 0;
   endfunction

   function int pending();
      return pending_bytes.size();
   endfunction

   function void add(logic [7:0] code, logic last);
      cmd_word_type w;
      w.code = code;
      w.last = last;
      pending_bytes.push_back(w);
   endfunction

   // predict the words caused by one accepted request
   function void note_request(logic [1:0] kind, logic [2:0] channel,
                              logic signed [15:0] freq, logic [3:0] volume,
                              logic [2:0] noise_type);
      logic [16:0] div;
      logic [7:0]  chan_bits;
      chan_bits = {1'b0, channel[1:0], 5'b0};
      case (kind)
         pce_pkg::KIND_TONE: begin
            if (channel <= 3'd2) begin
               if (freq <= 0) begin
                  add(TONE_ATTEN_CMD | chan_bits | {4'h0, ATTEN_OFF}, 1'b1);
               end else begin
                  div = tone_clock / {1'b0, freq};
                  if (div > 17'(pce_pkg::DIV_MAX)) div = 17'(pce_pkg::DIV_MAX);
                  add(TONE_LATCH_CMD | chan_bits | {4'h0, div[3:0]}, 1'b0);
                  add({2'b00, div[9:4]}, 1'b0);
                  add(TONE_ATTEN_CMD | chan_bits | {4'h0, volume}, 1'b1);
               end
            end
         end
         pce_pkg::KIND_NOISE: begin
            add(NOISE_CTRL_CMD | {5'b0, noise_type}, 1'b0);
            add(NOISE_ATTEN_CMD | {4'h0, volume}, 1'b1);
         end
         pce_pkg::KIND_SILENCE: begin
            for (int ch = 0; ch < 3; ch++)
               add(TONE_ATTEN_CMD | 8'(ch << 5) | {4'h0, ATTEN_OFF}, 1'b0);
            add(NOISE_ATTEN_CMD | {4'h0, ATTEN_OFF}, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function void check_byte(logic [7:0] code, logic last);
      cmd_word_type w;
      if (pending_bytes.size() == 0) begin
         fails++;
         $display("%0t: unexpected word, expected none, actual %02h last %0d",
                  $time, code, last);
      end else begin
         w = pending_bytes.pop_front();
         if (w.code !== code || w.last !== last) begin
            fails++;
            $display("%0t: word mismatch, expected %02h last %0d, actual %02h last %0d",
                     $time, w.code, w.last, code, last);
         end
      end
   endfunction
endclass

module tb_top;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 34;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [1:0]          req_kind = '0;
   logic [2:0]          req_channel = '0;
   logic signed [15:0]  req_frequency = '0;
   logic [3:0]          req_volume = '0;
   logic [2:0]          req_noise_type = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [7:0]          rsp_byte_res;
   logic                rsp_last;
   logic                csr_we = 1'b0;
   logic [16:0]         csr_wdata = '0;

   cmd_byte_ledger      ledger = new();
   bit                  steady_phase = 1'b0;
   int unsigned         pop_hold = 0;
   int                  stall_count = 0;

   psg_command_encoder i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_channel    (req_channel),
      .req_frequency  (req_frequency),
      .req_volume     (req_volume),
      .req_noise_type (req_noise_type),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_res   (rsp_byte_res),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      if (steady_phase || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // pop side: hold off a random number of cycles after each word
   always @(posedge clock) begin
      int unsigned w;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         w = draw_gap();
         pop_hold <= w;
         rsp_pop  <= (w == 0);
      end else if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= (pop_hold == 1);
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) ledger.check_byte(rsp_byte_res, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_req(logic [1:0] kind, logic [2:0] channel, logic signed [15:0] freq,
                           logic [3:0] volume, logic [2:0] noise_type);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_channel    <= channel;
      req_frequency  <= freq;
      req_volume     <= volume;
      req_noise_type <= noise_type;
      do @(posedge clock); while (req_full);
      ledger.note_request(kind, channel, freq, volume, noise_type);
   endtask

   // drain, then write the tone clock while the block is idle
   task automatic write_tone_clock(logic [16:0] value);
      req_push <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.tone_clock = value;
   endtask

   task automatic send_random_req();
      logic [1:0]         kind;
      logic [2:0]         channel;
      logic signed [15:0] freq;
      int                 base;
      int unsigned        pick;
      pick = $urandom_range(0, 19);
      if (pick < 10)      kind = pce_pkg::KIND_TONE;
      else if (pick < 14) kind = pce_pkg::KIND_NOISE;
      else if (pick < 18) kind = pce_pkg::KIND_SILENCE;
      else                kind = KIND_UNUSED;
      channel = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 2));
      case ($urandom_range(0, 4))
         0: freq = 16'($urandom);
         1: freq = 16'($urandom_range(1, 300));
         2: begin
            base = int'(ledger.tone_clock) / int'($urandom_range(1, 1100))
                   + int'($urandom_range(0, 4)) - 2;
            if (base < 1) base = 1;
            if (base > 32767) base = 32767;
            freq = 16'(base);
         end
         3: begin
            case ($urandom_range(0, 3))
               0: freq = 16'sd0;
               1: freq = -16'sd1;
               2: freq = 16'h8000;
               default: freq = 16'h7FFF;
            endcase
         end
         default: freq = 16'($urandom_range(1, 32767));
      endcase
      send_req(kind, channel, freq, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
   endtask

   initial begin
      logic [16:0] clock_values[PHASE_COUNT];
      clock_values = '{17'd131071, 17'd1, 17'd0, 17'd4000, 17'd0, 17'd0};
      clock_values[4] = 17'($urandom_range(0, 131071));
      clock_values[5] = pce_pkg::TONE_CLOCK_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset tone clock
      send_req(pce_pkg::KIND_TONE, 3'd0, 16'sd1, 4'd0, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd1, 16'sd32767, 4'd15, 3'd7);
      send_req(pce_pkg::KIND_TONE, 3'd2, 16'h8000, 4'd5, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd0, 16'sd0, 4'd3, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd2, -16'sd1, 4'd9, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd3, 16'sd100, 4'd1, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd7, 16'sd440, 4'd1, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd2, 16'sd109, 4'd7, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd1, 16'sd110, 4'd10, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd0, 16'sd440, 4'd7, 3'd0);
      send_req(pce_pkg::KIND_NOISE, 3'd0, 16'sd0, 4'd0, 3'd0);
      send_req(pce_pkg::KIND_NOISE, 3'd7, 16'hFFFF, 4'd15, 3'd7);
      send_req(pce_pkg::KIND_NOISE, 3'd2, 16'sd5, 4'd9, 3'd5);
      send_req(pce_pkg::KIND_SILENCE, 3'd0, 16'sd0, 4'd0, 3'd0);
      send_req(KIND_UNUSED, 3'd7, 16'hFFFF, 4'd15, 3'd7);
      send_req(pce_pkg::KIND_SILENCE, 3'd7, 16'hFFFF, 4'd15, 3'd7);

      write_tone_clock(17'd1);
      send_req(pce_pkg::KIND_TONE, 3'd0, 16'sd1, 4'd2, 3'd0);
      send_req(pce_pkg::KIND_TONE, 3'd1, 16'sd2, 4'd4, 3'd0);
      write_tone_clock(17'd0);
      send_req(pce_pkg::KIND_TONE, 3'd2, 16'sd1, 4'd6, 3'd0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_tone_clock(clock_values[p]);
         steady_phase = (p % 3 == 2);
         repeat (PHASE_ITEMS) send_random_req();
      end

      req_push <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.fails == 0 && ledger.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
